// ----- design/vtb_pkg.sv -----
// Package for the virtual timer bank: codes, widths and record types.
`timescale 1ns / 1ps
package vtb_pkg;
    localparam int NUM_TIMERS_DEF = 8;
    localparam logic [15:0] MIN_LEAD_RESET = 16'd250;

    localparam logic [3:0] FN_CREATE = 4'd0;
    localparam logic [3:0] FN_DELETE = 4'd1;
    localparam logic [3:0] FN_START  = 4'd2;
    localparam logic [3:0] FN_STOP   = 4'd3;
    localparam logic [3:0] FN_SETTM  = 4'd4;
    localparam logic [3:0] FN_QUERY  = 4'd5;
    localparam logic [3:0] FN_SETHND = 4'd6;
    localparam logic [3:0] FN_CANCEL = 4'd7;
    localparam logic [3:0] FN_TICK   = 4'd8;
    localparam logic [3:0] FN_RETURN = 4'd9;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN = 2'd1;
    localparam logic [1:0] ERR_RUNNING = 2'd2;
    localparam logic [1:0] ERR_BUSY    = 2'd3;

    // one timer slot record, held in the slot memory
    typedef struct packed {
        logic        valid;
        logic        active;
        logic        armed;
        logic [63:0] base;
        logic [63:0] accum;
        logic [63:0] sched;
        logic [31:0] handler;
        logic [31:0] common;
        logic [63:0] deadline;
    } slot_rec_t;

    typedef struct packed {
        logic [1:0]  error_code;
        logic        flag_out;
        logic [63:0] time_out;
        logic [63:0] base_out;
        logic [63:0] schedule_out;
        logic        dispatch_valid;
        logic [3:0]  dispatch_slot;
        logic [31:0] dispatch_handler;
        logic [31:0] dispatch_common;
    } result_t;

    // deadline for an armed alarm
    function automatic logic [63:0] alarm_deadline(input slot_rec_t r,
        input logic [63:0] sched, input logic [63:0] now, input logic [15:0] lead);
        logic [63:0] eff;
        logic [63:0] goal;
        logic [63:0] mingoal;
        begin
            eff = (sched < {48'd0, lead}) ? {48'd0, lead} : sched;
            goal = r.base + eff - r.accum;
            mingoal = now + {48'd0, lead};
            alarm_deadline = ($signed(goal) < $signed(mingoal)) ? mingoal : goal;
        end
    endfunction
endpackage

// ----- design/vtb_fifo.sv -----
// Fired-timer queue: push, pop, and removal of one slot by a compaction sweep.
`timescale 1ns / 1ps
module vtb_fifo
    import vtb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [3:0] push_slot,
    input  logic       pop,
    input  logic       purge,
    input  logic [3:0] purge_slot,
    output logic [3:0] head,
    output logic       not_empty,
    output logic       full
);
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    logic [3:0]    q_reg [NUM_TIMERS];
    logic [CW-1:0] cnt_reg;

    assign head      = q_reg[0];
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == CW'(NUM_TIMERS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (purge)
        begin
            logic [CW-1:0] w;
            w = '0;
            for (int r = 0; r < NUM_TIMERS; r++)
            begin
                if (CW'(r) < cnt_reg && q_reg[r] != purge_slot)
                begin
                    // w never passes r, so it stays inside the queue
                    q_reg[IW'(w)] <= q_reg[r];
                    w = w + 1'b1;
                end
            end
            cnt_reg <= w;
        end
        else if (pop)
        begin
            for (int i = 1; i < NUM_TIMERS; i++)
                q_reg[i-1] <= q_reg[i];
            cnt_reg <= cnt_reg - 1'b1;
        end
        else if (push && !full)
        begin
            q_reg[IW'(cnt_reg)] <= push_slot;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end
endmodule

// ----- design/virtual_timer_bank.sv -----
// Virtual timer bank top level: command sequencer around the slot memory.
// A timer command goes through a slot read and an execute state to its result; a
// handler return that must fetch the running slot's record passes through the
// execute state again. A tick scans every slot in turn, a registered read and then
// a check and write back for each. One item at a time: the next item is taken the
// cycle after the result leaves. Reset: all slots unused, queue empty, no handler
// running, min lead 250.
`timescale 1ns / 1ps
module virtual_timer_bank
    import vtb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tuser: func[3:0]
    input  logic [3:0]   s_axis_tuser,
    // tdata: timer_slot[3:0], now_us[67:4], operand_value[131:68],
    // handler_address[163:132], common_address[195:164], zero fill to 199
    input  logic [199:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: error_code[1:0], flag_out[2], time_out[66:3], base_out[130:67],
    // schedule_out[194:131], dispatch_valid[195], dispatch_slot[199:196],
    // dispatch_handler[231:200], dispatch_common[263:232], zero fill to 271
    output logic [271:0] m_axis_tdata
);
    localparam int AW = $clog2(NUM_TIMERS + 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;  // slot read issued
    localparam logic [2:0] ST_EXEC  = 3'd2;  // data back, modify and write
    localparam logic [2:0] ST_SCAN  = 3'd3;  // tick scan read issued
    localparam logic [2:0] ST_SCHK  = 3'd4;  // tick scan check/write
    localparam logic [2:0] ST_DREAD = 3'd5;  // dispatch read issued
    localparam logic [2:0] ST_DOUT  = 3'd6;  // dispatch data back
    localparam logic [2:0] ST_OUT   = 3'd7;  // result waiting

    logic [2:0]   st_reg, st_next;
    logic [15:0]  lead_reg;
    logic [199:0] cmd_reg;
    logic [3:0]   run_reg;
    logic [3:0]   scan_reg;
    result_t      res_reg;

    logic [3:0]  c_func, c_slot;
    logic [63:0] c_now, c_opv;
    logic [31:0] c_haddr, c_caddr;
    assign c_func  = cmd_reg[3:0];
    assign c_slot  = cmd_reg[7:4];
    assign c_now   = cmd_reg[71:8];
    assign c_opv   = cmd_reg[135:72];
    assign c_haddr = cmd_reg[167:136];
    assign c_caddr = cmd_reg[199:168];

    // slot memory, one entry per timer, one read and one write port, registered read
    slot_rec_t   mem [NUM_TIMERS+1];
    logic [AW-1:0] rd_addr;
    logic        rd_en;
    slot_rec_t   rd_data_reg;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    slot_rec_t   wr_data;
    // valid bits kept in flops so that reset clears the bank at once
    logic [NUM_TIMERS:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    logic [3:0] fq_head;
    logic fq_ne, fq_full, fq_push, fq_pop, fq_purge;
    logic [3:0] fq_push_slot;

    vtb_fifo #(.NUM_TIMERS(NUM_TIMERS)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push(fq_push), .push_slot(fq_push_slot),
        .pop(fq_pop), .purge(fq_purge), .purge_slot(c_slot),
        .head(fq_head), .not_empty(fq_ne), .full(fq_full)
    );

    function automatic logic in_range(input logic [3:0] s);
        in_range = (s >= 4'd1) && ({28'd0, s} <= 32'(NUM_TIMERS));
    endfunction

    function automatic logic [63:0] cur_time(input slot_rec_t r, input logic [63:0] now);
        cur_time = r.accum + (r.active ? now - r.base : 64'd0);
    endfunction

    // record with a new schedule, its alarm armed only if active with a handler
    function automatic slot_rec_t rearm(input slot_rec_t r, input logic [63:0] sched,
        input logic [63:0] now, input logic [15:0] lead);
        slot_rec_t o;
        begin
            o = r;
            o.armed = 1'b0;
            o.sched = sched;
            if (r.active && r.handler != 32'd0)
            begin
                o.armed = 1'b1;
                o.deadline = alarm_deadline(r, sched, now, lead);
            end
            rearm = o;
        end
    endfunction

    slot_rec_t cur, nrec;
    logic      vld;
    result_t   res_next;
    logic [3:0] run_next, scan_next;
    logic [NUM_TIMERS:0] valid_next;

    always_comb
    begin
        cur = rd_data_reg;
        cur.valid = 1'b1;
        nrec = cur;
        st_next = st_reg;
        res_next = res_reg;
        run_next = run_reg;
        scan_next = scan_reg;
        valid_next = valid_reg;
        rd_en = 1'b0;
        rd_addr = c_slot[AW-1:0];
        wr_en = 1'b0;
        wr_addr = c_slot[AW-1:0];
        wr_data = nrec;
        fq_push = 1'b0;
        fq_push_slot = scan_reg;
        fq_pop = 1'b0;
        fq_purge = 1'b0;
        vld = 1'b0;
        case (st_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                    st_next = ST_READ;
            end
            ST_READ:
            begin
                res_next = '0;
                if (c_func == FN_TICK)
                begin
                    scan_next = 4'd1;
                    rd_en = 1'b1;
                    rd_addr = AW'(1);
                    st_next = ST_SCAN;
                end
                else
                begin
                    rd_en = in_range(c_slot);
                    st_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                vld = in_range(c_slot) && valid_reg[c_slot[AW-1:0]];
                st_next = ST_OUT;
                if ((c_func == FN_START || c_func == FN_STOP || c_func == FN_SETHND ||
                     c_func == FN_CANCEL) && c_slot == run_reg)
                    res_next.error_code = ERR_RUNNING;
                else if (c_func == FN_CREATE)
                begin
                    if (!in_range(c_slot))
                        res_next.error_code = ERR_UNKNOWN;
                    else if (vld)
                        res_next.error_code = ERR_BUSY;
                    else
                    begin
                        nrec = '0;
                        nrec.valid = 1'b1;
                        nrec.deadline = cur.deadline;
                        wr_en = 1'b1;
                        wr_data = nrec;
                        valid_next[c_slot[AW-1:0]] = 1'b1;
                    end
                end
                else if (c_func <= FN_CANCEL)
                begin
                    if (!vld)
                        res_next.error_code = ERR_UNKNOWN;
                    else
                    begin
                        wr_en = 1'b1;
                        case (c_func)
                            FN_DELETE:
                            begin
                                fq_purge = 1'b1;
                                valid_next[c_slot[AW-1:0]] = 1'b0;
                                nrec.active = 1'b0;
                                nrec.armed = 1'b0;
                            end
                            FN_START:
                            begin
                                if (cur.active)
                                    res_next.flag_out = 1'b1;
                                else
                                begin
                                    nrec.active = 1'b1;
                                    nrec.base = c_now;
                                    if (cur.handler != 32'd0)
                                        nrec = rearm(nrec, cur.sched, c_now, lead_reg);
                                end
                            end
                            FN_STOP:
                            begin
                                if (cur.active)
                                begin
                                    nrec.accum = cur_time(cur, c_now);
                                    nrec.active = 1'b0;
                                    nrec.base = 64'd0;
                                    res_next.flag_out = 1'b1;
                                end
                            end
                            FN_SETTM:
                            begin
                                res_next.time_out = cur_time(cur, c_now);
                                nrec.accum = c_opv - (cur.active ? c_now - cur.base : 64'd0);
                                nrec = rearm(nrec, cur.sched, c_now, lead_reg);
                            end
                            FN_QUERY:
                            begin
                                wr_en = 1'b0;
                                res_next.flag_out = cur.active;
                                res_next.time_out = cur_time(cur, c_now);
                                res_next.base_out = cur.base;
                                res_next.schedule_out = cur.sched;
                            end
                            FN_SETHND:
                            begin
                                nrec.handler = c_haddr;
                                if (c_haddr != 32'd0)
                                begin
                                    nrec.common = c_caddr;
                                    nrec = rearm(nrec, c_opv, c_now, lead_reg);
                                end
                                else
                                    nrec = rearm(nrec, cur.sched, c_now, lead_reg);
                            end
                            default:
                            begin
                                nrec.armed = 1'b0;
                                nrec.handler = 32'd0;
                            end
                        endcase
                        wr_data = nrec;
                    end
                end
                else if (c_func == FN_RETURN)
                begin
                    if (run_reg != 4'd0)
                    begin
                        run_next = 4'd0;
                        if (in_range(run_reg) && valid_reg[run_reg[AW-1:0]] &&
                            run_reg == c_slot)
                        begin
                            wr_en = 1'b1;
                            if (c_opv[31:0] == 32'd0)
                            begin
                                nrec.armed = 1'b0;
                                nrec.handler = 32'd0;
                            end
                            else
                                nrec = rearm(cur, cur.sched + {32'd0, c_opv[31:0]},
                                             c_now, lead_reg);
                            wr_data = nrec;
                        end
                        else if (in_range(run_reg) && valid_reg[run_reg[AW-1:0]])
                        begin
                            // fetch the running slot's record instead
                            run_next = run_reg;
                            rd_en = 1'b1;
                            rd_addr = run_reg[AW-1:0];
                            st_next = ST_EXEC;
                        end
                    end
                end
                if (c_func == FN_RETURN && st_next == ST_EXEC)
                    res_next = res_reg;
            end
            ST_SCAN:
            begin
                st_next = ST_SCHK;
            end
            ST_SCHK:
            begin
                if (valid_reg[scan_reg[AW-1:0]] && cur.armed && cur.deadline <= c_now)
                begin
                    nrec.armed = 1'b0;
                    wr_en = 1'b1;
                    wr_addr = scan_reg[AW-1:0];
                    wr_data = nrec;
                    fq_push = 1'b1;
                end
                if ({28'd0, scan_reg} == 32'(NUM_TIMERS))
                begin
                    st_next = ST_DREAD;
                end
                else
                begin
                    scan_next = scan_reg + 4'd1;
                    rd_en = 1'b1;
                    rd_addr = AW'(scan_reg + 4'd1);
                    st_next = ST_SCAN;
                end
            end
            ST_DREAD:
            begin
                st_next = ST_OUT;
                if (run_reg == 4'd0 && fq_ne)
                begin
                    fq_pop = 1'b1;
                    scan_next = fq_head;
                    rd_en = in_range(fq_head);
                    rd_addr = fq_head[AW-1:0];
                    if (in_range(fq_head) && valid_reg[fq_head[AW-1:0]])
                        st_next = ST_DOUT;
                end
            end
            ST_DOUT:
            begin
                run_next = scan_reg;
                res_next.time_out = cur_time(cur, c_now);
                res_next.schedule_out = cur.sched;
                res_next.dispatch_valid = 1'b1;
                res_next.dispatch_slot = scan_reg;
                res_next.dispatch_handler = cur.handler;
                res_next.dispatch_common = cur.common;
                st_next = ST_OUT;
            end
            default:
            begin
                if (m_axis_tready)
                    st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            lead_reg <= MIN_LEAD_RESET;
            run_reg <= 4'd0;
            scan_reg <= 4'd0;
            valid_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            run_reg <= run_next;
            scan_reg <= scan_next;
            valid_reg <= valid_next;
            if (cfg_we)
                lead_reg <= cfg_wdata;
        end
    end

    // command word: func in the low nibble, then the tdata fields
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (st_reg == ST_IDLE && s_axis_tvalid)
            cmd_reg <= {s_axis_tdata[195:0], s_axis_tuser};
        else if (st_reg == ST_EXEC && st_next == ST_EXEC)
            cmd_reg[7:4] <= run_reg;   // second pass acts on the running slot
    end

    assign s_axis_tready = (st_reg == ST_IDLE);
    assign m_axis_tvalid = (st_reg == ST_OUT);
    assign m_axis_tdata  = {8'd0, res_reg.dispatch_common, res_reg.dispatch_handler,
                            res_reg.dispatch_slot, res_reg.dispatch_valid,
                            res_reg.schedule_out, res_reg.base_out, res_reg.time_out,
                            res_reg.flag_out, res_reg.error_code};
endmodule

// ----- design/vtb_checker.sv -----
// Port-level checks for the virtual timer bank, bound to the top level.
`timescale 1ns / 1ps
module vtb_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [271:0] m_axis_tdata
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");
    a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid && !s_axis_tready)
        else $error("result too early");
    a_dispatch_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[195] |-> m_axis_tdata[1:0] == 2'd0 &&
        m_axis_tdata[199:196] != 4'd0)
        else $error("bad dispatch result");
endmodule

bind virtual_timer_bank vtb_checker u_vtb_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// ----- tb/sv/tb_virtual_timer_bank.sv -----
// Testbench for the virtual timer bank: directed and random commands checked by a predictor.
`timescale 1ns / 1ps
module tb_virtual_timer_bank;
    import vtb_pkg::*;

    localparam int NT        = NUM_TIMERS_DEF;
    localparam int IDLE_LIMIT = 5000;   // cycles with no item moving on either side
    localparam int HOLD_LEN  = 400;     // long receiver hold-off, cycles
    localparam int SETTLE    = 40;      // idle after a drain, longer than a tick takes
    localparam int EXP_DEPTH = 16;      // expected-result ring

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [15:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // tuser: func
    logic [3:0]   s_axis_tuser;
    // tdata: timer_slot, now_us, operand_value, handler_address, common_address, zero fill
    logic [199:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // tdata: error_code, flag_out, time_out, base_out, schedule_out, dispatch_valid,
    // dispatch_slot, dispatch_handler, dispatch_common, zero fill
    logic [271:0] m_axis_tdata;

    virtual_timer_bank #(.NUM_TIMERS(NT)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // Predictor state: a private copy of the timer bank
    // ---------------------------------------------------------------
    logic [15:0] lead_us;
    logic        t_used   [1:NT];
    logic        t_run    [1:NT];
    logic        t_armed  [1:NT];
    logic [63:0] t_base   [1:NT];
    logic [63:0] t_accum  [1:NT];
    logic [63:0] t_sched  [1:NT];
    logic [63:0] t_due    [1:NT];
    logic [31:0] t_hnd    [1:NT];
    logic [31:0] t_arg    [1:NT];
    logic [3:0]  fired_fifo [0:NT-1];
    int          fired_cnt;
    logic [3:0]  busy_slot;        // slot whose handler is executing, 0 = none

    result_t exp_mem [0:EXP_DEPTH-1];
    int      exp_wr, exp_rd;

    int  n_items, n_results, n_dispatch, n_mismatch, n_fail_other;
    bit  quiet;                    // no idling on either side
    bit  hold_req;                 // ask receiver for a long hold-off
    logic [63:0] clock_us;         // running global time for random commands

    function automatic int exp_count();
        return exp_wr - exp_rd;
    endfunction

    function automatic void exp_put(result_t r);
        exp_mem[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endfunction

    function automatic result_t exp_take();
        result_t r;
        r = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        return r;
    endfunction

    function automatic bit is_known(logic [3:0] s);
        return s >= 1 && s <= NT && t_used[s];
    endfunction

    function automatic logic [63:0] timer_value(int s, logic [63:0] nw);
        return t_accum[s] + (t_run[s] ? nw - t_base[s] : 64'd0);
    endfunction

    // schedule an alarm, armed only if running with a handler, never before now plus min lead
    function automatic void arm_alarm(int s, logic [63:0] sched, logic [63:0] nw);
        logic [63:0] lead, eff, goal, floor_t;
        lead = {48'd0, lead_us};
        t_armed[s] = 1'b0;
        t_sched[s] = sched;
        if (t_run[s] && t_hnd[s] != 32'd0)
        begin
            eff = (sched < lead) ? lead : sched;
            goal = t_base[s] + eff - t_accum[s];
            floor_t = nw + lead;
            t_due[s] = ($signed(goal) < $signed(floor_t)) ? floor_t : goal;
            t_armed[s] = 1'b1;
        end
    endfunction

    function automatic void bank_clear();
        lead_us = MIN_LEAD_RESET;
        for (int i = 1; i <= NT; i++)
        begin
            t_used[i] = 0; t_run[i] = 0; t_armed[i] = 0;
            t_base[i] = '0; t_accum[i] = '0; t_sched[i] = '0; t_due[i] = '0;
            t_hnd[i] = '0; t_arg[i] = '0;
        end
        fired_cnt = 0;
        busy_slot = 4'd0;
    endfunction

    // expected result of one command; updates the bank copy
    function automatic result_t timer_bank_predict(logic [3:0] fn, logic [3:0] s,
        logic [63:0] nw, logic [63:0] opv, logic [31:0] ha, logic [31:0] ca);
        result_t r;
        int w;
        logic [3:0] d;
        r = '0;
        if ((fn == FN_START || fn == FN_STOP || fn == FN_SETHND || fn == FN_CANCEL)
            && s == busy_slot)
        begin
            r.error_code = ERR_RUNNING;
        end
        else if (fn == FN_CREATE)
        begin
            if (s < 1 || s > NT)
                r.error_code = ERR_UNKNOWN;
            else if (t_used[s])
                r.error_code = ERR_BUSY;
            else
            begin
                t_used[s] = 1; t_run[s] = 0; t_armed[s] = 0;
                t_base[s] = '0; t_accum[s] = '0; t_sched[s] = '0;
                t_hnd[s] = '0; t_arg[s] = '0;
            end
        end
        else if (fn <= FN_CANCEL)
        begin
            if (!is_known(s))
                r.error_code = ERR_UNKNOWN;
            else
            case (fn)
                FN_DELETE:
                begin
                    w = 0;
                    for (int i = 0; i < fired_cnt; i++)
                        if (fired_fifo[i] != s)
                        begin
                            fired_fifo[w] = fired_fifo[i];
                            w++;
                        end
                    fired_cnt = w;
                    t_used[s] = 0; t_run[s] = 0; t_armed[s] = 0;
                end
                FN_START:
                begin
                    if (t_run[s])
                        r.flag_out = 1'b1;
                    else
                    begin
                        t_run[s] = 1'b1;
                        t_base[s] = nw;
                        if (t_hnd[s] != 0)
                            arm_alarm(s, t_sched[s], nw);
                    end
                end
                FN_STOP:
                begin
                    // an armed alarm stays armed
                    if (t_run[s])
                    begin
                        t_accum[s] = timer_value(s, nw);
                        t_run[s] = 1'b0;
                        t_base[s] = '0;
                        r.flag_out = 1'b1;
                    end
                end
                FN_SETTM:
                begin
                    r.time_out = timer_value(s, nw);
                    t_accum[s] = opv - (t_run[s] ? nw - t_base[s] : 64'd0);
                    arm_alarm(s, t_sched[s], nw);
                end
                FN_QUERY:
                begin
                    r.flag_out = t_run[s];
                    r.time_out = timer_value(s, nw);
                    r.base_out = t_base[s];
                    r.schedule_out = t_sched[s];
                end
                FN_SETHND:
                begin
                    t_hnd[s] = ha;
                    if (ha != 0)
                    begin
                        t_arg[s] = ca;
                        arm_alarm(s, opv, nw);
                    end
                    else
                        arm_alarm(s, t_sched[s], nw);
                end
                default:
                begin
                    t_armed[s] = 1'b0;
                    t_hnd[s] = '0;
                end
            endcase
        end
        else if (fn == FN_TICK)
        begin
            for (int i = 1; i <= NT; i++)
                if (t_used[i] && t_armed[i] && t_due[i] <= nw)
                begin
                    t_armed[i] = 1'b0;
                    if (fired_cnt < NT)   // full queue drops the firing
                    begin
                        fired_fifo[fired_cnt] = i[3:0];
                        fired_cnt++;
                    end
                end
            if (busy_slot == 0 && fired_cnt > 0)
            begin
                d = fired_fifo[0];
                for (int i = 1; i < fired_cnt; i++)
                    fired_fifo[i-1] = fired_fifo[i];
                fired_cnt--;
                if (is_known(d))
                begin
                    busy_slot = d;
                    r.time_out = timer_value(d, nw);
                    r.schedule_out = t_sched[d];
                    r.dispatch_valid = 1'b1;
                    r.dispatch_slot = d;
                    r.dispatch_handler = t_hnd[d];
                    r.dispatch_common = t_arg[d];
                end
            end
        end
        else if (fn == FN_RETURN)
        begin
            // no handler running: nothing happens
            if (busy_slot != 0)
            begin
                d = busy_slot;
                busy_slot = 4'd0;
                if (is_known(d))
                begin
                    if (opv[31:0] == 32'd0)
                    begin
                        t_armed[d] = 1'b0;
                        t_hnd[d] = '0;
                    end
                    else
                        arm_alarm(d, t_sched[d] + {32'd0, opv[31:0]}, nw);
                end
            end
        end
        // codes above FN_RETURN: no effect, all-zero result
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // ---------------------------------------------------------------
    // Sender: one command item, predicted at acceptance
    // ---------------------------------------------------------------
    task automatic send_cmd(input logic [3:0] fn, input logic [3:0] s,
        input logic [63:0] nw, input logic [63:0] opv,
        input logic [31:0] ha, input logic [31:0] ca);
        result_t r;
        int g;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {4'd0, ca, ha, opv, nw, s};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        r = timer_bank_predict(fn, s, nw, opv, ha, ca);
        exp_put(r);
        n_items++;
        g = (quiet || $urandom_range(0, 9) < 7) ? 0 : gap_len();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // drop valid and wait for every outstanding result, then idle a little
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (exp_count() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_min_lead(input logic [15:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        lead_us = v;
        @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stalls plus an on-request long hold-off
    // ---------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = HOLD_LEN;
            end
            else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0)
                stall_left = gap_len();
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Result checker: field by field against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t act, exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            act.error_code       = m_axis_tdata[1:0];
            act.flag_out         = m_axis_tdata[2];
            act.time_out         = m_axis_tdata[66:3];
            act.base_out         = m_axis_tdata[130:67];
            act.schedule_out     = m_axis_tdata[194:131];
            act.dispatch_valid   = m_axis_tdata[195];
            act.dispatch_slot    = m_axis_tdata[199:196];
            act.dispatch_handler = m_axis_tdata[231:200];
            act.dispatch_common  = m_axis_tdata[263:232];
            if (exp_count() == 0)
            begin
                n_fail_other++;
                $display("[%0t] result with nothing expected: %h", $time, m_axis_tdata);
            end
            else
            begin
                exp_r = exp_take();
                n_results++;
                if (exp_r.dispatch_valid) n_dispatch++;
                if (act !== exp_r)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"[%0t] mismatch: err %0d/%0d flag %0d/%0d time %h/%h",
                                  " base %h/%h sched %h/%h disp %0d/%0d slot %0d/%0d",
                                  " hnd %h/%h arg %h/%h (exp/act)"}, $time,
                            exp_r.error_code, act.error_code, exp_r.flag_out, act.flag_out,
                            exp_r.time_out, act.time_out, exp_r.base_out, act.base_out,
                            exp_r.schedule_out, act.schedule_out,
                            exp_r.dispatch_valid, act.dispatch_valid,
                            exp_r.dispatch_slot, act.dispatch_slot,
                            exp_r.dispatch_handler, act.dispatch_handler,
                            exp_r.dispatch_common, act.dispatch_common);
                end
            end
        end
    end

    // watchdog: ends a run that stops moving
    always @(posedge clk)
    begin
        int still;
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            still = 0;
        else
            still++;
        if (still >= IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles, %0d results outstanding",
                     still, exp_count());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // error paths, each code, extremes, dispatch and the delete-while-running case
    task automatic test_directed();
        send_cmd(FN_CREATE, 4'd0, 64'd0, 64'd0, 32'd0, 32'd0);          // no timer
        send_cmd(FN_CREATE, 4'd9, 64'd0, 64'd0, 32'd0, 32'd0);          // above bank
        send_cmd(FN_START, 4'd0, 64'd0, 64'd0, 32'd0, 32'd0);           // slot 0 is "running"
        send_cmd(FN_QUERY, 4'd2, 64'd0, 64'd0, 32'd0, 32'd0);           // unused slot
        send_cmd(FN_CREATE, 4'd1, 64'd10, 64'd0, 32'd0, 32'd0);
        send_cmd(FN_CREATE, 4'd1, 64'd10, 64'd0, 32'd0, 32'd0);         // slot busy
        send_cmd(FN_START, 4'd1, 64'd1000, 64'd0, 32'd0, 32'd0);
        send_cmd(FN_START, 4'd1, 64'd1001, 64'd0, 32'd0, 32'd0);        // already active
        send_cmd(FN_SETHND, 4'd1, 64'd1000, 64'd300, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        send_cmd(FN_QUERY, 4'd1, 64'd1200, 64'd0, 32'd0, 32'd0);
        send_cmd(FN_TICK, 4'd0, 64'd1299, 64'd0, 32'd0, 32'd0);         // not due yet
        send_cmd(FN_TICK, 4'd0, 64'd1300, 64'd0, 32'd0, 32'd0);         // dispatch
        send_cmd(FN_STOP, 4'd1, 64'd1310, 64'd0, 32'd0, 32'd0);         // running handler
        send_cmd(FN_RETURN, 4'd0, 64'd1320, 64'd500, 32'd0, 32'd0);     // reschedule
        send_cmd(FN_RETURN, 4'd0, 64'd1321, 64'd5, 32'd0, 32'd0);       // none running
        send_cmd(FN_SETTM, 4'd1, 64'd1400, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd0);
        send_cmd(FN_TICK, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(FN_DELETE, 4'd1, 64'd2000, 64'd0, 32'd0, 32'd0);       // delete running timer
        send_cmd(FN_CREATE, 4'd1, 64'd2001, 64'd0, 32'd0, 32'd0);
        send_cmd(FN_RETURN, 4'd0, 64'd2002, 64'd0, 32'd0, 32'd0);       // acts on new timer
        send_cmd(FN_STOP, 4'd1, 64'd2003, 64'd0, 32'd0, 32'd0);         // not active
        send_cmd(FN_CANCEL, 4'd1, 64'd2004, 64'd0, 32'd0, 32'd0);
        send_cmd(4'd10, 4'd3, 64'd2005, 64'd0, 32'd0, 32'd0);           // unused codes
        send_cmd(4'd15, 4'd15, 64'd2006, 64'd7, 32'd1, 32'd1);
        send_cmd(FN_DELETE, 4'd1, 64'd2007, 64'd0, 32'd0, 32'd0);
    endtask

    // mostly well-formed traffic on a rising clock, some noise
    task automatic test_random(input int n);
        logic [3:0] fn, s;
        logic [63:0] opv;
        logic [31:0] ha;
        int p;
        for (int k = 0; k < n; k++)
        begin
            p = $urandom_range(0, 99);
            if (busy_slot != 0 && p < 30)         fn = FN_RETURN;
            else if (p < 55)                       fn = FN_TICK;
            else if (p < 63)                       fn = FN_CREATE;
            else if (p < 72)                       fn = FN_START;
            else if (p < 77)                       fn = FN_STOP;
            else if (p < 86)                       fn = FN_SETHND;
            else if (p < 89)                       fn = FN_SETTM;
            else if (p < 93)                       fn = FN_QUERY;
            else if (p < 95)                       fn = FN_DELETE;
            else if (p < 97)                       fn = FN_CANCEL;
            else if (p < 98)                       fn = FN_RETURN;
            else                                   fn = 4'($urandom_range(10, 15));
            s = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, NT));
            if ($urandom_range(0, 49) == 0)
                clock_us = rand64();
            else
                clock_us += 64'($urandom_range(0, 400));
            p = $urandom_range(0, 99);
            if (fn == FN_RETURN)
                opv = (p < 25) ? 64'd0 : (p < 85) ? 64'($urandom_range(1, 2000)) : rand64();
            else
                opv = (p < 70) ? 64'($urandom_range(0, 3000)) : (p < 85) ? 64'(lead_us)
                                                                       : rand64();
            ha = ($urandom_range(0, 6) == 0) ? 32'd0 : $urandom;
            send_cmd(fn, s, clock_us, opv, ha, $urandom);
        end
    endtask

    // receiver holds off for a long stretch while the sender keeps offering items
    task automatic test_backpressure();
        hold_req = 1'b1;
        test_random(40);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = '0;
        s_axis_tdata = '0;
        exp_wr = 0; exp_rd = 0;
        n_items = 0; n_results = 0; n_dispatch = 0; n_mismatch = 0; n_fail_other = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        clock_us = 64'd5000;
        bank_clear();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(250);                 // min lead at reset value
        test_backpressure();
        set_min_lead(16'd0);
        quiet = 1'b1;
        test_random(200);                 // back to back, no idling
        quiet = 1'b0;
        set_min_lead(16'hFFFF);
        test_random(200);
        set_min_lead(16'($urandom_range(1, 2000)));
        test_random(330);
        drain();

        if (exp_count() != 0)
            n_fail_other++;
        $display("%0d commands, %0d results checked, %0d handler dispatches,",
                 n_items, n_results, n_dispatch);
        $display("four min-lead settings, long output stall and idle-free stretch");
        $display("%0d mismatches, %0d other errors", n_mismatch, n_fail_other);
        if (n_mismatch == 0 && n_fail_other == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
